[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the RTL; compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// check that is switched off while reset is asserted
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// check that also holds during reset
`define ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(name, clk, rst_n, prop)
`define ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

[rtl/pmws_pkg.sv]
// ----------------------------------------------------------------------------
// pmws_pkg
// Constants for the median-of-three prefilter and windowed pressure sum.
// ----------------------------------------------------------------------------
package pmws_pkg;

    localparam int CFG_W            = 7;   // sample_count register width
    localparam int SAMPLE_COUNT_RST = 21;  // sample_count after reset
    localparam int MIN_WINDOW       = 2;   // shortest usable window
    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_BITS_DEF  = 20;

    // median ring slot encoding
    localparam logic [1:0] MSLOT_FIRST = 2'd0;
    localparam logic [1:0] MSLOT_LAST  = 2'd2;

endpackage

[rtl/pressure_median_window_sum.sv]
// Accepted items pass the middle stage into the result register; one item per cycle while out_ready stays high.
// The median, slot update and window memory access happen at input accept; the
// window read is registered and the running total is formed in the next stage.
// Reset (rst_n low, async) clears all control state, the window valid bits, the
// median ring, the running total, and loads sample_count with 21.
// ----------------------------------------------------------------------------
// pressure_median_window_sum
// Median-of-three prefilter feeding a window ring with a running sum over the last sample_count
// minus one filtered samples, with sample_count clamped to MIN_WINDOW..MAX_WINDOW.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pressure_median_window_sum #(
    parameter int MAX_WINDOW  = pmws_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = pmws_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration
    input  logic                                    cfg_we,
    input  logic [pmws_pkg::CFG_W-1:0]              cfg_wdata,
    // input channel
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [SAMPLE_BITS-1:0]                  pressure,
    // output channel
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [SAMPLE_BITS-1:0]                  filtered_pressure,
    output logic [SAMPLE_BITS+$clog2(MAX_WINDOW)-1:0] pressure_sum,
    output logic                                    window_ready,
    output logic                                    median_ready
);
    import pmws_pkg::*;

    // slot index width and width for window length compares
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int SLOT_CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W      = (SLOT_CNT_W > CFG_W) ? SLOT_CNT_W : CFG_W;
    localparam int TOTAL_W    = SAMPLE_BITS + IDX_W;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]       sample_count_reg;

    logic [SAMPLE_BITS-1:0] median_ring_reg [3];
    logic [1:0]             median_slot_reg;
    logic                   median_full_reg;

    logic [SAMPLE_BITS-1:0] window_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  window_valid_reg;
    logic [IDX_W-1:0]       window_slot_reg;
    logic                   window_full_reg;

    // middle stage: filtered value plus registered read of the retiring entry
    logic                   p_valid_reg;
    logic [SAMPLE_BITS-1:0] p_filt_reg;
    logic                   p_wfull_reg;
    logic                   p_mfull_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_valid_reg;

    // result register; total_reg doubles as the running total
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_filt_reg;
    logic                   out_wfull_reg;
    logic                   out_mfull_reg;
    logic [TOTAL_W-1:0]     total_reg;

    logic                   accept;
    logic                   advance;

    // retiring value and next running total
    logic [SAMPLE_BITS-1:0] old_val;
    logic [TOTAL_W-1:0]     total_next;

    // ------------------------------------------------------------------
    // handshake: the middle stage moves on when the result slot is free
    // or being emptied, and takes a new item whenever it moves or is empty
    // ------------------------------------------------------------------
    assign advance  = p_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !p_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    // ------------------------------------------------------------------
    // median prefilter (evaluated on the incoming sample)
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] m0, m1, m2;
    logic [SAMPLE_BITS-1:0] m_lo, m_hi, m_med;
    logic [SAMPLE_BITS-1:0] filt;
    logic [1:0]             median_slot_next;
    logic                   median_full_next;
    logic [1:0]             mslot;

    always_comb
    begin
        // an out-of-range slot is treated as the first one
        mslot = (median_slot_reg > MSLOT_LAST) ? MSLOT_FIRST : median_slot_reg;

        m0 = (mslot == 2'd0) ? pressure : median_ring_reg[0];
        m1 = (mslot == 2'd1) ? pressure : median_ring_reg[1];
        m2 = (mslot == 2'd2) ? pressure : median_ring_reg[2];

        m_lo  = (m0 < m1) ? m0 : m1;
        m_hi  = (m0 < m1) ? m1 : m0;
        if (m2 <= m_lo)
        begin
            m_med = m_lo;
        end
        else if (m2 >= m_hi)
        begin
            m_med = m_hi;
        end
        else
        begin
            m_med = m2;
        end

        median_full_next = median_full_reg || (mslot == MSLOT_LAST);
        median_slot_next = (mslot == MSLOT_LAST) ? MSLOT_FIRST : mslot + 2'd1;

        // raw sample passes until the ring has filled once
        filt = median_full_next ? m_med : pressure;
    end

    // ------------------------------------------------------------------
    // window slot bookkeeping
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] count_ext;
    logic [LEN_W-1:0] win_len;
    logic [LEN_W-1:0] slot_ext;
    logic [LEN_W-1:0] cur_ext;
    logic [LEN_W-1:0] wnext_ext;
    logic             wrap;
    logic [IDX_W-1:0] cur_idx;
    logic [IDX_W-1:0] wnext_idx;

    always_comb
    begin
        count_ext = LEN_W'(sample_count_reg);
        if (count_ext < LEN_W'(MIN_WINDOW))
        begin
            win_len = LEN_W'(MIN_WINDOW);
        end
        else if (count_ext > LEN_W'(MAX_WINDOW))
        begin
            win_len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            win_len = count_ext;
        end

        slot_ext  = LEN_W'(window_slot_reg);
        cur_ext   = (slot_ext >= LEN_W'(MAX_WINDOW)) ? '0 : slot_ext;
        // a slot left beyond a shortened window wraps like a normal wrap
        wnext_ext = cur_ext + LEN_W'(1);
        wrap      = (wnext_ext >= win_len);
        if (wrap)
        begin
            wnext_ext = '0;
        end

        cur_idx   = cur_ext[IDX_W-1:0];
        wnext_idx = wnext_ext[IDX_W-1:0];
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= CFG_W'(SAMPLE_COUNT_RST);
            median_ring_reg  <= '{default: '0};
            median_slot_reg  <= MSLOT_FIRST;
            median_full_reg  <= 1'b0;
            window_valid_reg <= '0;
            window_slot_reg  <= '0;
            window_full_reg  <= 1'b0;
            p_valid_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            total_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                sample_count_reg <= cfg_wdata;
            end

            if (accept)
            begin
                median_ring_reg[mslot]    <= pressure;
                median_slot_reg           <= median_slot_next;
                median_full_reg           <= median_full_next;
                window_valid_reg[cur_idx] <= 1'b1;
                window_slot_reg           <= wnext_idx;
                window_full_reg           <= window_full_reg || wrap;
            end

            if (accept)
            begin
                p_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                p_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // window memory: write the new value at the current slot, read the
    // entry that leaves the sum; the two addresses never coincide
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_mem[cur_idx] <= filt;
            rd_data_reg         <= window_mem[wnext_idx];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_filt_reg   <= filt;
            p_wfull_reg  <= window_full_reg || wrap;
            p_mfull_reg  <= median_full_next;
            rd_valid_reg <= window_valid_reg[wnext_idx];
        end
        if (advance)
        begin
            out_filt_reg  <= p_filt_reg;
            out_wfull_reg <= p_wfull_reg;
            out_mfull_reg <= p_mfull_reg;
        end
    end

    // ------------------------------------------------------------------
    // running total, modulo 2^TOTAL_W; unwritten entries read as zero
    // ------------------------------------------------------------------
    always_comb
    begin
        old_val    = rd_valid_reg ? rd_data_reg : '0;
        total_next = total_reg + TOTAL_W'(p_filt_reg) - TOTAL_W'(old_val);
    end

    assign out_valid         = out_valid_reg;
    assign filtered_pressure = out_filt_reg;
    assign pressure_sum      = total_reg;
    assign window_ready      = out_wfull_reg;
    assign median_ready      = out_mfull_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_rd_not_wr_slot, clk, rst_n, accept |-> (wnext_idx != cur_idx))
    `ASSERT_CLK(a_accept_fills_stage, clk, rst_n, accept |=> p_valid_reg)
    `ASSERT_CLK(a_median_full_sticky, clk, rst_n, median_full_reg |=> median_full_reg)
    `ASSERT_CLK(a_result_held, clk, rst_n,
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(total_reg)))
    `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> (!p_valid_reg && !out_valid_reg))

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: pressure_median_window_sum
// Drives raw pressure samples through random valid/ready traffic under a
// sequence of window lengths, predicts the median prefilter and the windowed
// running sum in a small scoreboard, and compares every result item field by
// field in order.
// ----------------------------------------------------------------------------
module tb;
    import pmws_pkg::*;

    localparam int SW          = SAMPLE_BITS_DEF;
    localparam int TW          = SAMPLE_BITS_DEF + $clog2(MAX_WINDOW_DEF);
    localparam int ITEM_TARGET = 1200;  // random items, roughly
    localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int SETTLE      = 4;     // margin after the last result

    localparam logic [SW-1:0] P_MAX = '1;

    // one result item as the block presents it
    typedef struct {
        logic [SW-1:0] filtered;
        logic [TW-1:0] sum;
        logic          window_ok;
        logic          median_ok;
    } reading_t;

    // ------------------------------------------------------------------------
    // Scoreboard: its own copy of the filter and window state. take_sample is
    // called for each accepted input item and queues the expected reading;
    // check_reading pops the oldest one and compares.
    // ------------------------------------------------------------------------
    class median_sum_tracker;
        logic [SW-1:0]    median_ring [3];
        int               median_slot;
        bit               median_full;
        logic [SW-1:0]    window_ring [MAX_WINDOW_DEF];
        int               window_slot;
        bit               window_full;
        logic [TW-1:0]    total;
        logic [CFG_W-1:0] sample_count;
        reading_t         pending [$];
        int               errors;

        function new();
            foreach (median_ring[i]) median_ring[i] = '0;
            foreach (window_ring[i]) window_ring[i] = '0;
            median_slot  = 0;
            median_full  = 0;
            window_slot  = 0;
            window_full  = 0;
            total        = '0;
            sample_count = CFG_W'(SAMPLE_COUNT_RST);
            errors       = 0;
        endfunction

        function void set_length(logic [CFG_W-1:0] value);
            sample_count = value;
        endfunction

        function void take_sample(logic [SW-1:0] raw);
            logic [SW-1:0] lo, hi, third, filt;
            int            len, cur, nxt;
            reading_t      r;

            // median-of-three prefilter; raw passes until the ring has filled
            median_ring[median_slot] = raw;
            nxt = median_slot + 1;
            if (nxt >= 3)
            begin
                nxt         = 0;
                median_full = 1;
            end
            median_slot = nxt;

            lo    = (median_ring[0] < median_ring[1]) ? median_ring[0] : median_ring[1];
            hi    = (median_ring[0] < median_ring[1]) ? median_ring[1] : median_ring[0];
            third = median_ring[2];
            if (!median_full)
                filt = raw;
            else if (third <= lo)
                filt = lo;
            else if (third >= hi)
                filt = hi;
            else
                filt = third;

            // window length is clamped, not rejected
            len = sample_count;
            if (len < MIN_WINDOW)
                len = MIN_WINDOW;
            if (len > MAX_WINDOW_DEF)
                len = MAX_WINDOW_DEF;

            // a slot left past the end by a shorter window wraps like a normal wrap
            cur = window_slot;
            if (cur >= MAX_WINDOW_DEF)
                cur = 0;
            nxt = cur + 1;
            if (nxt >= len)
            begin
                nxt         = 0;
                window_full = 1;
            end
            window_ring[cur] = filt;
            total = total + {{(TW-SW){1'b0}}, filt} - {{(TW-SW){1'b0}}, window_ring[nxt]};
            window_slot = nxt;

            r.filtered  = filt;
            r.sum       = total;
            r.window_ok = window_full;
            r.median_ok = median_full;
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_reading(reading_t got);
            reading_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("result item with nothing pending (filtered=%h sum=%h)",
                                 got.filtered, got.sum));
                return;
            end
            want = pending.pop_front();
            if (got.filtered !== want.filtered)
                report($sformatf("filtered_pressure %h, want %h", got.filtered, want.filtered));
            if (got.sum !== want.sum)
                report($sformatf("pressure_sum %h, want %h", got.sum, want.sum));
            if (got.window_ok !== want.window_ok)
                report($sformatf("window_ready %b, want %b", got.window_ok, want.window_ok));
            if (got.median_ok !== want.median_ok)
                report($sformatf("median_ready %b, want %b", got.median_ok, want.median_ok));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block connections; every input starts at a known value
    // ------------------------------------------------------------------------
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = CFG_W'(SAMPLE_COUNT_RST);
    logic             in_valid  = 1'b0;
    logic             in_ready;
    logic [SW-1:0]    pressure  = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [SW-1:0]    filtered_pressure;
    logic [TW-1:0]    pressure_sum;
    logic             window_ready;
    logic             median_ready;

    // when set, neither side inserts gaps (back-to-back stretches)
    bit no_idle = 1'b0;

    median_sum_tracker tracker = new();

    pressure_median_window_sum dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .pressure          (pressure),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .filtered_pressure (filtered_pressure),
        .pressure_sum      (pressure_sum),
        .window_ready      (window_ready),
        .median_ready      (median_ready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // per-item gap or stall length, shared by both sides
    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // ------------------------------------------------------------------------
    // Handshake monitor. Inputs are noted before outputs are checked, so the
    // order within one edge never matters. Signals are read in the active
    // region of the edge, before any of this edge's nonblocking updates.
    // ------------------------------------------------------------------------
    initial
    begin
        reading_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (in_valid && in_ready)
                    tracker.take_sample(pressure);
                if (out_valid && out_ready)
                begin
                    got.filtered  = filtered_pressure;
                    got.sum       = pressure_sum;
                    got.window_ok = window_ready;
                    got.median_ok = median_ready;
                    tracker.check_reading(got);
                end
            end
        end
    end

    // watchdog: too long without any handshake on either channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // result side: stall a random number of cycles per result item, then
    // hold ready high until one is taken
    initial
    begin
        int stall;
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks; each is entered right after a rising edge
    // ------------------------------------------------------------------------

    // register write; only called with nothing in flight
    task write_length(input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.set_length(value);
    endtask

    // valid is only dropped when a gap is drawn, so back-to-back items keep
    // it high without a low/high pair in the same step
    task send_sample(input logic [SW-1:0] value);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pressure <= value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // sender holds off until every expected result has come back
    task drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // one random phase: new window length, then a run of samples in one style
    task run_phase(input logic [CFG_W-1:0] len, input int count, input int style);
        logic [SW-1:0] base, value;
        int            k;
        write_length(len);
        base = SW'($urandom_range(1000, 20'hFFC00));
        for (k = 0; k < count; k++)
        begin
            case (style)
                0: value = SW'($urandom);                              // anything
                1: value = SW'($urandom_range(20'hFFF00, 20'hFFFFF));  // near full scale
                2: value = SW'($urandom_range(0, 255));                // near zero
                3: value = ($urandom_range(0, 1) == 1) ? P_MAX : '0;   // rail to rail
                default:
                begin
                    // slow drift with noise and the odd spike for the median to reject
                    base  = base + SW'($urandom_range(0, 16)) - SW'(8);
                    value = base + SW'($urandom_range(0, 63));
                    if ($urandom_range(0, 7) == 0)
                        value = SW'($urandom);
                end
            endcase
            send_sample(value);
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [CFG_W-1:0] len_edges [8];
        int               sent;
        int               pick;
        int               n_items;

        len_edges = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd63, 7'd64, 7'd65, 7'd127};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // shortest window; first two samples pass raw, third already a median,
        // then median picked as the lower of the first pair, twice, and as the third
        write_length(7'd2);
        send_sample('0);
        send_sample(P_MAX);
        send_sample(20'h12345);
        send_sample(P_MAX);
        send_sample(20'h55555);
        send_sample(20'hAAAAA);
        drain_results();

        // length below the minimum is clamped up
        write_length(7'd0);
        send_sample(20'h80000);
        send_sample(20'h7FFFF);
        send_sample(20'h00001);
        drain_results();

        // length above the maximum is clamped down; leaves the slot at 7
        write_length(7'd127);
        repeat (6) send_sample(P_MAX);
        drain_results();

        // shrink below the current slot: it must wrap and mark the window full
        write_length(7'd3);
        repeat (3) send_sample('0);
        drain_results();

        write_length(7'd1);
        send_sample(P_MAX);
        send_sample('0);
        drain_results();

        // random phases: extreme and random lengths, mixed sample styles,
        // some phases run back to back with no gaps on either side
        sent = 0;
        while (sent < ITEM_TARGET)
        begin
            pick    = $urandom_range(0, 3);
            no_idle = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(1, 150);
            if (pick == 0)
                run_phase(len_edges[$urandom_range(0, 7)], n_items, $urandom_range(0, 4));
            else
                run_phase(CFG_W'($urandom_range(0, 127)), n_items, $urandom_range(0, 4));
            sent = sent + n_items;
        end

        no_idle = 1'b0;
        drain_results();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
